### rtl/core/frame_receive_crc_checker_top_defines.svh
// Assertion macros used by the top module to check its own logic.
`ifndef FRAME_RECEIVE_CRC_CHECKER_TOP_DEFINES_SVH
`define FRAME_RECEIVE_CRC_CHECKER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define FRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define FRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/core/frc_pkg.sv
package frc_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    localparam logic [15:0] MaxReceiveReset = 16'd1024;
    localparam logic [7:0]  IdleLimitReset  = 8'd1;

    // Frame layout, in byte indexes.
    localparam logic [16:0] HdrBytes      = 17'd16;
    localparam logic [16:0] LenLoIdx      = 17'd14;
    localparam logic [16:0] LenHiIdx      = 17'd15;
    localparam logic [15:0] FrameOverhead = 16'd18;

    localparam logic [16:0] ByteCountMax = 17'h1ffff;
    localparam logic [7:0]  IdleCountMax = 8'hff;

    // Request op codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MAX_RECEIVE = 1'b0;
    localparam logic CFG_IDLE_LIMIT  = 1'b1;

    // Nibble table for polynomial 0x1021.
    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
        16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
    };

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTE,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd_item;

    function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return {crc[11:0], 4'h0} ^ NIB_TAB[idx];
    endfunction

    // High nibble first, as the CRC is not reflected.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        return crc_nibble(crc_nibble(crc, b[7:4]), b[3:0]);
    endfunction

endpackage

### rtl/core/frc_front.sv
module frc_front #(
    parameter int unsigned QueueDepth = frc_pkg::QueueDepthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_data_byte,
    output logic                o_q_valid,
    output frc_pkg::t_cmd_item  o_q_item,
    input  logic                i_q_pop
);
    import frc_pkg::*;

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

    t_cmd_item           r_mem [QueueDepth];
    logic [PtrW-1:0]     r_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr;
    logic [CntW-1:0]     r_count;

    t_cmd_item           w_item;
    logic                w_known;
    logic                w_push;
    logic                w_pop;

    // Requests with the unused op code are taken and dropped here.
    always_comb begin
        w_known     = 1'b1;
        w_item.data = i_data_byte;
        w_item.kind = CMD_START;
        unique case (i_op)
            OP_START: w_item.kind = CMD_START;
            OP_BYTE:  w_item.kind = CMD_BYTE;
            OP_TICK:  w_item.kind = CMD_TICK;
            default:  w_known = 1'b0;
        endcase
    end

    assign o_in_stall = (r_count == FullCnt);
    assign w_push     = i_in_valid && !o_in_stall && w_known;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/frc_back.sv
module frc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  frc_pkg::t_cmd_item  i_q_item,
    output logic                o_q_pop,
    input  logic [15:0]         i_max_receive,
    input  logic [7:0]          i_idle_limit,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [15:0]         o_frame_length,
    output logic [15:0]         o_payload_length,
    output logic [15:0]         o_computed_crc
);
    import frc_pkg::*;

    logic        r_receiving;
    logic [16:0] r_byte_count;
    logic [15:0] r_length_field;
    logic [15:0] r_running_crc;
    logic [7:0]  r_trailer_low;
    logic [7:0]  r_idle_count;

    logic        n_receiving;
    logic [16:0] n_byte_count;
    logic [15:0] n_length_field;
    logic [15:0] n_running_crc;
    logic [7:0]  n_trailer_low;
    logic [7:0]  n_idle_count;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [15:0] r_frame_length;
    logic [15:0] r_payload_length;
    logic [15:0] r_computed_crc;

    logic        w_pop;
    logic        w_emit;
    logic        w_done;
    logic [1:0]  w_status;
    logic [16:0] w_body;
    logic [16:0] w_body_next;
    logic [16:0] w_bc_inc;
    logic [7:0]  w_idle_inc;
    logic [7:0]  w_limit;

    // A request is taken whenever the output register is free or being emptied.
    assign w_pop   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = w_pop;

    assign w_body      = {1'b0, r_length_field} + HdrBytes;
    assign w_body_next = w_body + 17'd1;
    assign w_bc_inc    = (r_byte_count != ByteCountMax) ? r_byte_count + 17'd1 : r_byte_count;
    assign w_idle_inc  = (r_idle_count != IdleCountMax) ? r_idle_count + 8'd1 : r_idle_count;
    assign w_limit     = (i_idle_limit == '0) ? 8'd1 : i_idle_limit;

    always_comb begin
        n_receiving    = r_receiving;
        n_byte_count   = r_byte_count;
        n_length_field = r_length_field;
        n_running_crc  = r_running_crc;
        n_trailer_low  = r_trailer_low;
        n_idle_count   = r_idle_count;
        w_emit         = 1'b0;
        w_done         = 1'b0;
        w_status       = ST_OK;
        if (w_pop) begin
            unique case (i_q_item.kind)
                CMD_START: begin
                    n_receiving    = 1'b1;
                    n_byte_count   = '0;
                    n_length_field = '0;
                    n_running_crc  = '0;
                    n_trailer_low  = '0;
                    n_idle_count   = '0;
                end
                CMD_TICK: begin
                    if (r_receiving) begin
                        n_idle_count = w_idle_inc;
                        if (w_idle_inc >= w_limit) begin
                            w_emit   = 1'b1;
                            w_status = ST_TIMEOUT;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (r_receiving) begin
                        n_idle_count = '0;
                        n_byte_count = w_bc_inc;
                        if (r_byte_count < HdrBytes || r_byte_count < w_body) begin
                            n_running_crc = crc_byte(r_running_crc, i_q_item.data);
                            if (r_byte_count == LenLoIdx) begin
                                n_length_field[7:0] = i_q_item.data;
                            end else if (r_byte_count == LenHiIdx) begin
                                n_length_field[15:8] = i_q_item.data;
                            end
                        end else if (r_byte_count == w_body) begin
                            n_trailer_low = i_q_item.data;
                        end else if (r_byte_count == w_body_next) begin
                            w_done   = 1'b1;
                            w_emit   = 1'b1;
                            w_status = ({i_q_item.data, r_trailer_low} == r_running_crc) ?
                                       ST_OK : ST_CRC_ERR;
                        end
                        // A completed frame takes precedence over buffer full.
                        if (!w_done && w_bc_inc >= {1'b0, i_max_receive}) begin
                            w_emit   = 1'b1;
                            w_status = ST_FULL;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (w_emit) begin
                n_receiving = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving    <= 1'b0;
            r_byte_count   <= '0;
            r_length_field <= '0;
            r_running_crc  <= '0;
            r_trailer_low  <= '0;
            r_idle_count   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_receiving    <= n_receiving;
            r_byte_count   <= n_byte_count;
            r_length_field <= n_length_field;
            r_running_crc  <= n_running_crc;
            r_trailer_low  <= n_trailer_low;
            r_idle_count   <= n_idle_count;
            if (w_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_status         <= w_status;
            r_frame_length   <= n_byte_count[16] ? 16'hffff : n_byte_count[15:0];
            r_payload_length <= n_length_field;
            r_computed_crc   <= n_running_crc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_frame_length   = r_frame_length;
    assign o_payload_length = r_payload_length;
    assign o_computed_crc   = r_computed_crc;

endmodule

### rtl/core/frame_receive_crc_checker_top.sv
// Frame receiver with a CRC-16 (poly 0x1021, init 0) check over header and payload.
// The input channel carries one request per item: start a receive, a data byte, or a
// time tick. The output channel carries at most one result per request: frame ok, CRC
// mismatch, buffer full or idle timeout, with the frame length, the header length
// field and the computed CRC.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// An accepted request is first written into the queue and executed from there by the
// back end, which registers its result and shows it on the output from then on. One
// request is executed every cycle while no stalled result holds the back end; the
// combinational byte CRC update in the back end sets that rate.
// A short queue sits between the request decoder and the back end. While the
// receiver stalls a result, the back end holds and the queue keeps taking requests
// until it is full, at which point the input stall is raised.
// The user must write configuration registers through the plain write port only
// while the block is idle; the block does not enforce this. Reset (synchronous, active
// low) empties the queue, drops any result, ends any receive, restores register defaults.
`include "frame_receive_crc_checker_top_defines.svh"

module frame_receive_crc_checker_top #(
    parameter int unsigned QueueDepth = frc_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_computed_crc
);
    import frc_pkg::*;

    logic [15:0] r_max_receive;
    logic [7:0]  r_idle_limit;

    logic        w_q_valid;
    t_cmd_item   w_q_item;
    logic        w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_receive <= MaxReceiveReset;
            r_idle_limit  <= IdleLimitReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_RECEIVE: r_max_receive <= i_cfg_wdata;
                CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    frc_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    frc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .i_max_receive    (r_max_receive),
        .i_idle_limit     (r_idle_limit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_frame_length   (o_frame_length),
        .o_payload_length (o_payload_length),
        .o_computed_crc   (o_computed_crc)
    );

    `FRC_ASSERT(a_result_needs_request, i_clk, i_rst_n, !o_out_valid |=> !o_out_valid || $past(w_q_pop), "A result appeared without a request being executed.")
    `FRC_ASSERT(a_frame_min_length, i_clk, i_rst_n, o_out_valid && (o_status == ST_OK || o_status == ST_CRC_ERR) |-> o_frame_length >= FrameOverhead, "A completed frame is shorter than header and trailer.")
    `FRC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "Reset left a result or a full queue behind.")

endmodule

### test/frame_report_checker.sv
`timescale 1ns / 1ps

package frame_check_pkg;

    import frc_pkg::*;

    // The op code that the block leaves unused; it must be ignored.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_BAD_CRC,
        FAULT_TRUNCATED,
        FAULT_ABANDONED
    } t_frame_fault;

    // Bit-serial CRC-16, most significant bit of the byte first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            if (c[15] ^ b[k]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

module frame_report_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_payload_length,
    input  logic [15:0] i_computed_crc,
    output int          o_fail_count,
    output int          o_awaiting,
    output int          o_ok_count,
    output int          o_crc_err_count,
    output int          o_full_count,
    output int          o_timeout_count
);

    import frc_pkg::*;
    import frame_check_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frame_length;
        logic [15:0] length_field;
        logic [15:0] crc;
    } t_frame_report;

    t_frame_report expected_reports[$];

    // Own copy of the register settings and of the receive state.
    logic [15:0] limit_bytes;
    logic [7:0]  limit_ticks;
    logic        rx_active;
    logic [16:0] rx_count;
    logic [15:0] rx_len_field;
    logic [15:0] rx_crc;
    logic [7:0]  rx_trailer_lo;
    logic [7:0]  rx_idle_ticks;

    task automatic start_frame();
        rx_active     = 1'b1;
        rx_count      = '0;
        rx_len_field  = '0;
        rx_crc        = '0;
        rx_trailer_lo = '0;
        rx_idle_ticks = '0;
    endtask

    task automatic close_frame(input logic [1:0] status);
        t_frame_report rep;
        rep.status       = status;
        rep.frame_length = (rx_count > 17'h0ffff) ? 16'hffff : rx_count[15:0];
        rep.length_field = rx_len_field;
        rep.crc          = rx_crc;
        expected_reports.push_back(rep);
        rx_active = 1'b0;
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [7:0] b);
        logic [16:0] idx;
        logic [16:0] body;
        logic [7:0]  lim;
        if (op == OP_START) begin
            start_frame();
        end else if (rx_active && op == OP_TICK) begin
            lim = (limit_ticks == 8'd0) ? 8'd1 : limit_ticks;
            if (rx_idle_ticks != 8'hff) begin
                rx_idle_ticks++;
            end
            if (rx_idle_ticks >= lim) begin
                close_frame(ST_TIMEOUT);
            end
        end else if (rx_active && op == OP_BYTE) begin
            idx  = rx_count;
            body = {1'b0, rx_len_field} + 17'd16;
            rx_idle_ticks = '0;
            if (rx_count != 17'h1ffff) begin
                rx_count++;
            end
            // The body always covers the whole header, so the length bytes land here.
            if (idx < body) begin
                rx_crc = crc16_feed(rx_crc, b);
                if (idx == 17'd14) begin
                    rx_len_field[7:0] = b;
                end else if (idx == 17'd15) begin
                    rx_len_field[15:8] = b;
                end
            end else if (idx == body) begin
                rx_trailer_lo = b;
            end else if (idx == body + 17'd1) begin
                close_frame(({b, rx_trailer_lo} == rx_crc) ? ST_OK : ST_CRC_ERR);
            end
            // A frame that completes on the last allowed byte is not reported as full.
            if (rx_active && rx_count >= {1'b0, limit_bytes}) begin
                close_frame(ST_FULL);
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("Mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
            end
        end
    endtask

    task automatic check_report();
        t_frame_report want;
        if (expected_reports.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("Unexpected result at %0t: status %0d length %0d field %h crc %h",
                         $time, i_status, i_frame_length, i_payload_length, i_computed_crc);
            end
        end else begin
            want = expected_reports.pop_front();
            compare_field("status", 16'(want.status), 16'(i_status));
            compare_field("frame_length", want.frame_length, i_frame_length);
            compare_field("payload_length", want.length_field, i_payload_length);
            compare_field("computed_crc", want.crc, i_computed_crc);
            case (i_status)
                ST_OK:      o_ok_count++;
                ST_CRC_ERR: o_crc_err_count++;
                ST_FULL:    o_full_count++;
                default:    o_timeout_count++;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_reports.delete();
            limit_bytes     = MaxReceiveReset;
            limit_ticks     = IdleLimitReset;
            rx_active       = 1'b0;
            rx_count        = '0;
            rx_len_field    = '0;
            rx_crc          = '0;
            rx_trailer_lo   = '0;
            rx_idle_ticks   = '0;
            o_fail_count    = 0;
            o_ok_count      = 0;
            o_crc_err_count = 0;
            o_full_count    = 0;
            o_timeout_count = 0;
        end else begin
            // A result can never belong to a request accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                check_report();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_op, i_data_byte);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_RECEIVE) begin
                    limit_bytes = i_cfg_wdata;
                end else begin
                    limit_ticks = i_cfg_wdata[7:0];
                end
            end
        end
        o_awaiting = expected_reports.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import frc_pkg::*;
    import frame_check_pkg::*;

    localparam int SETTLE_CYCLES = 12;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  in_op     = OP_TICK;
    logic [7:0]  in_data   = 8'h00;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_MAX_RECEIVE;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        out_stall = 1'b0;
    logic [15:0] stall_cycle = '0;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [15:0] frame_length;
    logic [15:0] payload_length;
    logic [15:0] computed_crc;

    int fail_count;
    int awaiting;
    int ok_count;
    int crc_err_count;
    int full_count;
    int timeout_count;

    int          sent       = 0;
    int          settings   = 0;
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;
    int unsigned cur_max    = MaxReceiveReset;
    int unsigned cur_idle   = IdleLimitReset;

    frame_receive_crc_checker_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_op             (in_op),
        .i_data_byte      (in_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_frame_length   (frame_length),
        .o_payload_length (payload_length),
        .o_computed_crc   (computed_crc)
    );

    frame_report_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_op             (in_op),
        .i_data_byte      (in_data),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_frame_length   (frame_length),
        .i_payload_length (payload_length),
        .i_computed_crc   (computed_crc),
        .o_fail_count     (fail_count),
        .o_awaiting       (awaiting),
        .o_ok_count       (ok_count),
        .o_crc_err_count  (crc_err_count),
        .o_full_count     (full_count),
        .o_timeout_count  (timeout_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver changes its stall behaviour in phases chosen by bits 11 to 9 of stall_cycle.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall   <= 1'b0;
            stall_cycle <= '0;
        end else begin
            stall_cycle <= stall_cycle + 16'd1;
            case (stall_cycle[11:9])
                3'd0, 3'd4: begin
                    out_stall <= 1'b0;
                end
                3'd1: begin
                    out_stall <= ($urandom_range(99, 0) < 30);
                end
                3'd2: begin
                    out_stall <= (stall_cycle[2:0] < 3'd3);
                end
                3'd3: begin
                    out_stall <= (stall_cycle[5:0] < 6'd20);
                end
                3'd5: begin
                    out_stall <= ($urandom_range(99, 0) < 70);
                end
                default: begin
                    out_stall <= stall_cycle[3] ^ stall_cycle[1];
                end
            endcase
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] data);
        if (burst_left == 0) begin
            burst_left = $urandom_range(40, 1);
            if (gaps_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_op    <= op;
        in_data  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Hold off until every expected result is back and the block has gone quiet.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // The upper byte of the idle limit write is junk that the block must drop.
    task automatic program_limits(input logic [15:0] max_bytes, input logic [7:0] idle_ticks);
        drain();
        write_reg(CFG_MAX_RECEIVE, max_bytes);
        write_reg(CFG_IDLE_LIMIT, {8'($urandom), idle_ticks});
        cfg_we   <= 1'b0;
        cur_max  = max_bytes;
        cur_idle = idle_ticks;
        settings++;
    endtask

    task automatic send_frame(input int unsigned len, input t_frame_fault fault);
        logic [15:0] crc;
        logic [7:0]  b;
        int unsigned total;
        int unsigned cut;
        int unsigned bad_at;
        int unsigned eff_idle;
        crc      = '0;
        total    = len + 18;
        eff_idle = (cur_idle == 0) ? 1 : cur_idle;
        cut      = total;
        if (fault == FAULT_TRUNCATED || fault == FAULT_ABANDONED) begin
            cut = $urandom_range(total - 1, 0);
        end
        // Anything past the buffer limit is ignored by the block anyway.
        if (cut > cur_max + 2) begin
            cut = cur_max + 2;
        end
        bad_at = $urandom_range(total - 1, 0);
        send_request(OP_START, 8'($urandom));
        for (int unsigned i = 0; i < cut; i++) begin
            if (i == 14) begin
                b = len[7:0];
            end else if (i == 15) begin
                b = len[15:8];
            end else if (i == len + 16) begin
                b = crc[7:0];
            end else if (i == len + 17) begin
                b = crc[15:8];
            end else begin
                b = 8'($urandom);
            end
            if (i < len + 16) begin
                crc = crc16_feed(crc, b);
            end
            if (fault == FAULT_BAD_CRC && i == bad_at) begin
                b = b ^ (8'h01 << $urandom_range(7, 0));
            end
            if (eff_idle > 1 && $urandom_range(11, 0) == 0) begin
                repeat ($urandom_range((eff_idle - 1 < 6) ? eff_idle - 1 : 6, 1)) begin
                    send_request(OP_TICK, 8'($urandom));
                end
            end
            if ($urandom_range(29, 0) == 0) begin
                send_request(OP_RESERVED, 8'($urandom));
            end
            send_request(OP_BYTE, b);
        end
        if (fault == FAULT_TRUNCATED) begin
            repeat (eff_idle + $urandom_range(2, 0)) send_request(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic run_random_case();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99, 0);
        len  = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 0) : $urandom_range(20, 0);
        if ($urandom_range(49, 0) == 0) begin
            drain();
        end
        if (pick < 55) begin
            send_frame(len, FAULT_NONE);
        end else if (pick < 70) begin
            send_frame(len, FAULT_BAD_CRC);
        end else if (pick < 78) begin
            send_frame(len, FAULT_TRUNCATED);
        end else if (pick < 85) begin
            send_frame(len, FAULT_ABANDONED);
        end else if (pick < 92) begin
            repeat ($urandom_range(4, 1)) begin
                case ($urandom_range(2, 0))
                    0: begin
                        send_request(OP_TICK, 8'($urandom));
                    end
                    1: begin
                        send_request(OP_BYTE, 8'($urandom));
                    end
                    default: begin
                        send_request(OP_RESERVED, 8'($urandom));
                    end
                endcase
            end
        end else if (cur_max <= 300) begin
            // Header claims more payload than the buffer can take.
            send_frame($urandom_range(65535, cur_max), FAULT_NONE);
        end else begin
            send_frame(len, FAULT_NONE);
        end
    endtask

    initial begin
        logic [15:0] crc;
        logic [7:0]  b;
        logic [15:0] new_max;
        logic [7:0]  new_idle;
        int          phase_end;
        int unsigned eff_idle;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // While idle, bytes, ticks and the reserved op are all ignored; then a start and a tick time out.
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, 8'hff);
        send_request(OP_RESERVED, 8'h5a);
        send_request(OP_START, 8'h00);
        send_request(OP_TICK, 8'hff);

        // A zero buffer limit fills on the first byte; a zero idle limit acts as one.
        program_limits(16'd0, 8'd0);
        send_request(OP_START, 8'h00);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_START, 8'h00);
        send_request(OP_START, 8'hff);
        send_request(OP_TICK, 8'h00);

        // An empty-payload frame that completes exactly on the buffer limit.
        program_limits(16'd18, 8'd255);
        crc = '0;
        send_request(OP_START, 8'h00);
        for (int i = 0; i < 18; i++) begin
            if (i < 16) begin
                b   = (i == 14 || i == 15) ? 8'h00 : 8'hff;
                crc = crc16_feed(crc, b);
            end else begin
                b = (i == 16) ? crc[7:0] : crc[15:8];
            end
            send_request(OP_BYTE, b);
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    new_max  = 16'hffff;
                    new_idle = 8'd255;
                end
                1: begin
                    new_max  = 16'd64;
                    new_idle = 8'd2;
                end
                2: begin
                    new_max  = 16'd300;
                    new_idle = 8'd5;
                end
                3: begin
                    new_max  = 16'd1;
                    new_idle = 8'd1;
                end
                4: begin
                    new_max  = 16'($urandom_range(150, 30));
                    new_idle = 8'($urandom_range(8, 1));
                end
                default: begin
                    new_max  = MaxReceiveReset;
                    new_idle = IdleLimitReset;
                end
            endcase
            program_limits(new_max, new_idle);
            gaps_on   = (p % 3 != 2);
            phase_end = sent + 240;
            while (sent < phase_end) run_random_case();
            // Leave the block idle before the registers change again.
            eff_idle = (cur_idle == 0) ? 1 : cur_idle;
            send_request(OP_START, 8'($urandom));
            repeat (eff_idle) send_request(OP_TICK, 8'($urandom));
        end

        drain();
        $display("Sent %0d requests over %0d register settings,", sent, settings);
        $display("with sender gaps and output stalls.");
        $display("Results checked: %0d ok, %0d crc mismatch, %0d buffer full, %0d idle timeout.",
                 ok_count, crc_err_count, full_count, timeout_count);
        if (fail_count == 0 && awaiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", fail_count, awaiting);
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Run timed out with %0d results outstanding", awaiting);
        $display("== FAIL ==");
        $finish;
    end

endmodule
